/* hdl/vle_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vle_pkg
// Shared constants, codes and types of the value list engine.
// ----------------------------------------------------------------------------
package vle_pkg;

    localparam int DEPTH       = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int CNT_FIELD_W = 5;

    localparam int IN_BITS     = OP_W + 2 * DATA_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STATUS_W + 3 * DATA_W + 2 * CNT_FIELD_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd4;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd5;
    localparam logic [OP_W-1:0] OP_STATS  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage
`default_nettype wire

/* hdl/vle_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vle_mem
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vle_mem
(
    input  wire logic                            clk,
    input  wire vle_pkg::mem_req_t               req,
    output logic     [vle_pkg::DATA_W-1:0]       rd_data
);

    logic [vle_pkg::DATA_W-1:0] entries_mem [vle_pkg::DEPTH];
    logic [vle_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entries_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= entries_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* hdl/vle_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vle_cmp
// Shared compare unit: equality and signed less-than of two entries.
// ----------------------------------------------------------------------------
module vle_cmp
(
    input  wire logic [vle_pkg::DATA_W-1:0] a,
    input  wire logic [vle_pkg::DATA_W-1:0] b,
    output vle_pkg::cmp_res_t               res
);

    always_comb
    begin
        res.eq = (a == b);
        res.lt = ($signed(a) < $signed(b));
    end

endmodule
`default_nettype wire

/* hdl/value_list_engine_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// value_list_engine_unit
// Ordered list of signed 32-bit values with append, search, modify, delete,
// list, sort and statistics operations.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time and is not ready until the
// command has put its final result into the output register. All work goes
// through an entry memory with one write and one read port, a registered read
// and one shared compare unit. Each visited entry takes a read and an examine
// state for search, modify and list, a read and a write state for delete
// shifting, and a read, a largest and a smallest state for statistics. Sort
// is an exchange sort that compares entry i with each later entry per pass.
// A result beat may wait in the output register while the next command is
// accepted; list results stall the walk while the output is not taken.
// ----------------------------------------------------------------------------
module value_list_engine_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // operation[2:0], key[34:3], value[66:35], zero fill above
    input  wire logic [vle_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // status[1:0], item_value[33:2], largest[65:34], smallest[97:66],
    // even_count[102:98], odd_count[107:103], zero fill above
    output logic      [vle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                    m_axis_tlast
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_APPEND,
        S_FIND_RD,
        S_FIND_EX,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST_RD,
        S_LIST_EX,
        S_SORT_RDI,
        S_SORT_GETI,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_SORT_WRI,
        S_STAT_RD,
        S_STAT_MAX,
        S_STAT_MIN,
        S_EMIT
    } state_t;

    localparam int AW = vle_pkg::ADDR_W;
    localparam int CW = vle_pkg::CNT_W;
    localparam int DW = vle_pkg::DATA_W;

    state_t                       state_reg;
    logic [vle_pkg::OP_W-1:0]     op_reg;
    logic [DW-1:0]                key_reg;
    logic [DW-1:0]                val_reg;
    logic [AW-1:0]                idx_reg;
    logic [AW-1:0]                jdx_reg;
    logic [CW-1:0]                count_reg;
    logic [DW-1:0]                cur_reg;
    logic [vle_pkg::STATUS_W-1:0] res_status_reg;
    logic [DW-1:0]                res_item_reg;
    logic                         res_last_reg;
    logic [DW-1:0]                big_reg;
    logic [DW-1:0]                small_reg;
    logic [CW-1:0]                even_reg;
    logic [CW-1:0]                odd_reg;
    logic                         out_valid_reg;
    logic [vle_pkg::STATUS_W-1:0] out_status_reg;
    logic [DW-1:0]                out_item_reg;
    logic [DW-1:0]                out_big_reg;
    logic [DW-1:0]                out_small_reg;
    logic [CW-1:0]                out_even_reg;
    logic [CW-1:0]                out_odd_reg;
    logic                         out_last_reg;

    vle_pkg::mem_req_t            mem_req;
    vle_pkg::cmp_res_t            cmp_res;
    logic [DW-1:0]                rd_data;
    logic [DW-1:0]                cmp_a;
    logic [DW-1:0]                cmp_b;

    logic                         accept;
    logic [vle_pkg::OP_W-1:0]     in_op;
    logic [DW-1:0]                in_key;
    logic [DW-1:0]                in_val;
    logic                         out_free;
    logic                         full;
    logic                         idx_last;
    logic                         idx_next_last;
    logic                         jdx_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tdata[vle_pkg::OP_W-1:0];
    assign in_key        = s_axis_tdata[vle_pkg::OP_W +: DW];
    assign in_val        = s_axis_tdata[vle_pkg::OP_W + DW +: DW];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign full          = (count_reg == CW'(vle_pkg::DEPTH));
    assign idx_last      = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign idx_next_last = ((CW'(idx_reg) + CW'(2)) == count_reg);
    assign jdx_last      = ((CW'(jdx_reg) + CW'(1)) == count_reg);

    vle_mem u_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    vle_cmp u_cmp
    (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    always_comb
    begin
        cmp_a = rd_data;
        cmp_b = key_reg;
        case (state_reg)
            S_SORT_CMP:
            begin
                cmp_b = cur_reg;
            end
            S_STAT_MAX:
            begin
                cmp_a = big_reg;
                cmp_b = rd_data;
            end
            S_STAT_MIN:
            begin
                cmp_b = small_reg;
            end
            default:
            begin
                cmp_b = key_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            S_APPEND:
            begin
                mem_req.wr_en   = !full;
                mem_req.wr_addr = count_reg[AW-1:0];
                mem_req.wr_data = val_reg;
            end
            S_FIND_RD, S_LIST_RD, S_SORT_RDI, S_STAT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
            end
            S_FIND_EX:
            begin
                mem_req.wr_en   = cmp_res.eq && (op_reg == vle_pkg::OP_MODIFY);
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = val_reg;
            end
            S_SHIFT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg + AW'(1);
            end
            S_SHIFT_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = rd_data;
            end
            S_SORT_RDJ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = jdx_reg;
            end
            S_SORT_CMP:
            begin
                mem_req.wr_en   = cmp_res.lt;
                mem_req.wr_addr = jdx_reg;
                mem_req.wr_data = cur_reg;
            end
            S_SORT_WRI:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = cur_reg;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            key_reg        <= '0;
            val_reg        <= '0;
            idx_reg        <= '0;
            jdx_reg        <= '0;
            count_reg      <= '0;
            cur_reg        <= '0;
            res_status_reg <= vle_pkg::ST_OK;
            res_item_reg   <= '0;
            res_last_reg   <= 1'b0;
            big_reg        <= '0;
            small_reg      <= '0;
            even_reg       <= '0;
            odd_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= vle_pkg::ST_OK;
            out_item_reg   <= '0;
            out_big_reg    <= '0;
            out_small_reg  <= '0;
            out_even_reg   <= '0;
            out_odd_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg         <= in_op;
                        key_reg        <= in_key;
                        val_reg        <= in_val;
                        idx_reg        <= '0;
                        res_status_reg <= vle_pkg::ST_OK;
                        res_item_reg   <= '0;
                        res_last_reg   <= 1'b1;
                        big_reg        <= '0;
                        small_reg      <= '0;
                        even_reg       <= '0;
                        odd_reg        <= '0;
                        if (in_op == vle_pkg::OP_APPEND)
                        begin
                            state_reg <= S_APPEND;
                        end
                        else if (in_op > vle_pkg::OP_STATS)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_reg <= vle_pkg::ST_EMPTY;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            case (in_op)
                                vle_pkg::OP_LIST:
                                begin
                                    state_reg <= S_LIST_RD;
                                end
                                vle_pkg::OP_SORT:
                                begin
                                    state_reg <= (count_reg == CW'(1)) ? S_EMIT : S_SORT_RDI;
                                end
                                vle_pkg::OP_STATS:
                                begin
                                    state_reg <= S_STAT_RD;
                                end
                                default:
                                begin
                                    state_reg <= S_FIND_RD;
                                end
                            endcase
                        end
                    end
                end
                S_APPEND:
                begin
                    if (full)
                    begin
                        res_status_reg <= vle_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= S_EMIT;
                end
                S_FIND_RD:
                begin
                    state_reg <= S_FIND_EX;
                end
                S_FIND_EX:
                begin
                    if (cmp_res.eq)
                    begin
                        if (op_reg == vle_pkg::OP_DELETE && !idx_last)
                        begin
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            if (op_reg == vle_pkg::OP_DELETE)
                            begin
                                count_reg <= count_reg - CW'(1);
                            end
                            state_reg <= S_EMIT;
                        end
                    end
                    else if (idx_last)
                    begin
                        res_status_reg <= vle_pkg::ST_NOT_FOUND;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_FIND_RD;
                    end
                end
                S_SHIFT_RD:
                begin
                    state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (idx_next_last)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_RD;
                    end
                end
                S_LIST_RD:
                begin
                    state_reg <= S_LIST_EX;
                end
                S_LIST_EX:
                begin
                    res_item_reg <= rd_data;
                    res_last_reg <= idx_last;
                    state_reg    <= S_EMIT;
                end
                S_SORT_RDI:
                begin
                    state_reg <= S_SORT_GETI;
                end
                S_SORT_GETI:
                begin
                    cur_reg   <= rd_data;
                    jdx_reg   <= idx_reg + AW'(1);
                    state_reg <= S_SORT_RDJ;
                end
                S_SORT_RDJ:
                begin
                    state_reg <= S_SORT_CMP;
                end
                S_SORT_CMP:
                begin
                    if (cmp_res.lt)
                    begin
                        cur_reg <= rd_data;
                    end
                    if (jdx_last)
                    begin
                        state_reg <= S_SORT_WRI;
                    end
                    else
                    begin
                        jdx_reg   <= jdx_reg + AW'(1);
                        state_reg <= S_SORT_RDJ;
                    end
                end
                S_SORT_WRI:
                begin
                    idx_reg   <= idx_reg + AW'(1);
                    state_reg <= idx_next_last ? S_EMIT : S_SORT_RDI;
                end
                S_STAT_RD:
                begin
                    state_reg <= S_STAT_MAX;
                end
                S_STAT_MAX:
                begin
                    if (idx_reg == '0)
                    begin
                        big_reg   <= rd_data;
                        small_reg <= rd_data;
                    end
                    else if (cmp_res.lt)
                    begin
                        big_reg <= rd_data;
                    end
                    if (rd_data[0])
                    begin
                        odd_reg <= odd_reg + CW'(1);
                    end
                    else
                    begin
                        even_reg <= even_reg + CW'(1);
                    end
                    state_reg <= S_STAT_MIN;
                end
                S_STAT_MIN:
                begin
                    if (cmp_res.lt)
                    begin
                        small_reg <= rd_data;
                    end
                    if (idx_last)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_STAT_RD;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_item_reg   <= res_item_reg;
                        out_big_reg    <= big_reg;
                        out_small_reg  <= small_reg;
                        out_even_reg   <= even_reg;
                        out_odd_reg    <= odd_reg;
                        out_last_reg   <= res_last_reg;
                        if (res_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_LIST_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{vle_pkg::OUT_PAD_W{1'b0}},
                            vle_pkg::CNT_FIELD_W'(out_odd_reg),
                            vle_pkg::CNT_FIELD_W'(out_even_reg),
                            out_small_reg,
                            out_big_reg,
                            out_item_reg,
                            out_status_reg};

    // The list never holds more entries than there is room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(vle_pkg::DEPTH))
        else $error("entry count above depth");

    // An append or a delete moves the count by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + CW'(1)) ||
         (count_reg + CW'(1) == $past(count_reg))))
        else $error("entry count jumped");

    // A walk over the entries stays inside the stored part of the list.
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND_EX || state_reg == S_LIST_EX ||
         state_reg == S_STAT_MAX || state_reg == S_STAT_MIN ||
         state_reg == S_SORT_CMP) |->
        ((CW'(idx_reg) < count_reg) && (CW'(jdx_reg) < count_reg ||
                                         state_reg != S_SORT_CMP)))
        else $error("entry walk out of range");

    // An empty-list answer is always the only beat of its command.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == vle_pkg::ST_EMPTY) |-> out_last_reg)
        else $error("empty status without last");

endmodule
`default_nettype wire

/* tb/vle_result_checker.sv */
// ----------------------------------------------------------------------------
// vle_result_checker
// Predicts and checks every result beat of the value list engine.
// ----------------------------------------------------------------------------
// Watches both stream ports. Each accepted command beat is run through a
// shadow copy of the list, and the result beats it must produce are queued.
// Each accepted result beat is compared field by field with the oldest
// queued beat. Mismatches, unexpected beats and the pending count are handed
// to the testbench top.
// ----------------------------------------------------------------------------
module vle_result_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    // operation[2:0], key[34:3], value[66:35], zero fill above
    input  wire logic [vle_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // status[1:0], item_value[33:2], largest[65:34], smallest[97:66],
    // even_count[102:98], odd_count[107:103], zero fill above
    input  wire logic [vle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                               m_axis_tlast,
    output int                                      mismatch_count,
    output int                                      pending_beats,
    output int                                      beats_checked
);

    import vle_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [DATA_W-1:0]      item_value;
        logic [DATA_W-1:0]      largest;
        logic [DATA_W-1:0]      smallest;
        logic [CNT_FIELD_W-1:0] even_count;
        logic [CNT_FIELD_W-1:0] odd_count;
        logic                   last;
    } result_beat_t;

    result_beat_t             expected_beats[$];
    logic signed [DATA_W-1:0] shadow_list [DEPTH];
    int                       shadow_count;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100)
        begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("beat %0d %s: got %h, expected %h",
                                      beats_checked, name, got, want));
        end
    endtask

    task automatic push_beat(input logic [STATUS_W-1:0] status,
                             input logic [DATA_W-1:0] item_value,
                             input logic [DATA_W-1:0] largest,
                             input logic [DATA_W-1:0] smallest,
                             input int evens, input int odds, input logic last);
        result_beat_t beat;
        beat.status     = status;
        beat.item_value = item_value;
        beat.largest    = largest;
        beat.smallest   = smallest;
        beat.even_count = CNT_FIELD_W'(evens);
        beat.odd_count  = CNT_FIELD_W'(odds);
        beat.last       = last;
        expected_beats.push_back(beat);
    endtask

    task automatic apply_command(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] key,
                                 input logic signed [DATA_W-1:0] value);
        int                       hit;
        int                       i;
        int                       j;
        int                       evens;
        int                       odds;
        logic signed [DATA_W-1:0] swap_val;
        logic signed [DATA_W-1:0] top_val;
        logic signed [DATA_W-1:0] bottom_val;
        hit = -1;
        for (i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_list[i] == key)
            begin
                hit = i;
            end
        end
        case (op)
            OP_APPEND:
            begin
                if (shadow_count >= DEPTH)
                begin
                    push_beat(ST_FULL, '0, '0, '0, 0, 0, 1'b1);
                end
                else
                begin
                    shadow_list[shadow_count] = value;
                    shadow_count++;
                    push_beat(ST_OK, '0, '0, '0, 0, 0, 1'b1);
                end
            end
            OP_SEARCH, OP_MODIFY, OP_DELETE, OP_LIST, OP_SORT, OP_STATS:
            begin
                if (shadow_count == 0)
                begin
                    push_beat(ST_EMPTY, '0, '0, '0, 0, 0, 1'b1);
                end
                else if (op == OP_LIST)
                begin
                    for (i = 0; i < shadow_count; i++)
                    begin
                        push_beat(ST_OK, shadow_list[i], '0, '0, 0, 0,
                                  i == shadow_count - 1);
                    end
                end
                else if (op == OP_SORT)
                begin
                    for (i = 0; i < shadow_count; i++)
                    begin
                        for (j = i + 1; j < shadow_count; j++)
                        begin
                            if (shadow_list[j] < shadow_list[i])
                            begin
                                swap_val       = shadow_list[j];
                                shadow_list[j] = shadow_list[i];
                                shadow_list[i] = swap_val;
                            end
                        end
                    end
                    push_beat(ST_OK, '0, '0, '0, 0, 0, 1'b1);
                end
                else if (op == OP_STATS)
                begin
                    top_val    = shadow_list[0];
                    bottom_val = shadow_list[0];
                    evens      = 0;
                    odds       = 0;
                    for (i = 0; i < shadow_count; i++)
                    begin
                        if (shadow_list[i] > top_val)
                        begin
                            top_val = shadow_list[i];
                        end
                        if (shadow_list[i] < bottom_val)
                        begin
                            bottom_val = shadow_list[i];
                        end
                        if (shadow_list[i][0])
                        begin
                            odds++;
                        end
                        else
                        begin
                            evens++;
                        end
                    end
                    push_beat(ST_OK, '0, top_val, bottom_val, evens, odds, 1'b1);
                end
                else if (hit < 0)
                begin
                    push_beat(ST_NOT_FOUND, '0, '0, '0, 0, 0, 1'b1);
                end
                else
                begin
                    if (op == OP_MODIFY)
                    begin
                        shadow_list[hit] = value;
                    end
                    else if (op == OP_DELETE)
                    begin
                        for (i = hit; i < shadow_count - 1; i++)
                        begin
                            shadow_list[i] = shadow_list[i + 1];
                        end
                        shadow_count--;
                    end
                    push_beat(ST_OK, '0, '0, '0, 0, 0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        result_beat_t want;
        if (!rst_n)
        begin
            expected_beats.delete();
            shadow_count  = 0;
            pending_beats = 0;
            beats_checked = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch($sformatf("beat %0d arrived with no command pending",
                                              beats_checked));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("status", m_axis_tdata[0 +: STATUS_W], want.status);
                    compare_field("item_value", m_axis_tdata[STATUS_W +: DATA_W],
                                  want.item_value);
                    compare_field("largest", m_axis_tdata[STATUS_W + DATA_W +: DATA_W],
                                  want.largest);
                    compare_field("smallest", m_axis_tdata[STATUS_W + 2 * DATA_W +: DATA_W],
                                  want.smallest);
                    compare_field("even_count",
                                  m_axis_tdata[STATUS_W + 3 * DATA_W +: CNT_FIELD_W],
                                  want.even_count);
                    compare_field("odd_count",
                                  m_axis_tdata[STATUS_W + 3 * DATA_W + CNT_FIELD_W +:
                                               CNT_FIELD_W],
                                  want.odd_count);
                    compare_field("last", m_axis_tlast, want.last);
                    compare_field("zero fill", m_axis_tdata[OUT_TDATA_W-1:OUT_BITS], '0);
                end
                beats_checked++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_command(s_axis_tdata[0 +: OP_W], s_axis_tdata[OP_W +: DATA_W],
                              s_axis_tdata[OP_W + DATA_W +: DATA_W]);
            end
            pending_beats = expected_beats.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the value list engine.
// ----------------------------------------------------------------------------
// Drives a directed set of commands covering empty, extreme, negative and
// missing-key cases, then a long output hold-off that backs up the input,
// then random command phases that grow, mix and shrink the list. Both ports
// idle in random bursts except in the final phase. The checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

    import vle_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 186;
    localparam int PHASE_ITEMS   = 31;
    localparam int LAST_PHASE    = 5;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    int                     mismatch_count;
    int                     pending_beats;
    int                     beats_checked;
    logic                   hold_req;
    logic                   calm;
    int                     commands_sent;

    value_list_engine_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    vle_result_checker result_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats),
        .beats_checked  (beats_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] key,
                                input logic [DATA_W-1:0] value);
        int gap;
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, value, key, op};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (op != OP_UNUSED)
        begin
            commands_sent++;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_beats != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return DATA_W'($urandom_range(0, 15) - 8);
        end
        else if (r < 8)
        begin
            return $urandom();
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int phase);
        int append_w;
        int delete_w;
        int r;
        case (phase)
            0, 3:
            begin
                append_w = 65;
                delete_w = 10;
            end
            2:
            begin
                append_w = 10;
                delete_w = 55;
            end
            default:
            begin
                append_w = 30;
                delete_w = 20;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < append_w)
        begin
            return OP_APPEND;
        end
        else if (r < append_w + delete_w)
        begin
            return OP_DELETE;
        end
        r = $urandom_range(0, 20);
        if (r == 0)
        begin
            return OP_UNUSED;
        end
        else if (r <= 4)
        begin
            return OP_SEARCH;
        end
        else if (r <= 8)
        begin
            return OP_MODIFY;
        end
        else if (r <= 12)
        begin
            return OP_LIST;
        end
        else if (r <= 16)
        begin
            return OP_SORT;
        end
        return OP_STATS;
    endfunction

    initial
    begin : output_stall
        int stall_left;
        bit hold_taken;
        stall_left    = 0;
        hold_taken    = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 15)
            begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Timeout: no beat moved for %0d cycles.", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int random_sent;
        int phase;
        int prev_phase;
        logic [OP_W-1:0] op;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_req      = 1'b0;
        calm          = 1'b0;
        commands_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every command that needs an entry, on an empty list.
        send_command(OP_SEARCH, 32'h0, 32'h0);
        send_command(OP_MODIFY, 32'h0, 32'h1);
        send_command(OP_DELETE, 32'h0, 32'h0);
        send_command(OP_LIST, 32'h0, 32'h0);
        send_command(OP_SORT, 32'h0, 32'h0);
        send_command(OP_STATS, 32'h0, 32'h0);

        // Extremes and negative values of both parities.
        send_command(OP_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_command(OP_APPEND, 32'h0, 32'h8000_0000);
        send_command(OP_APPEND, 32'h0, 32'hFFFF_FFFD);
        send_command(OP_APPEND, 32'h0, 32'hFFFF_FFFC);
        send_command(OP_STATS, 32'h0, 32'h0);
        send_command(OP_LIST, 32'h0, 32'h0);
        send_command(OP_SEARCH, 32'hFFFF_FFFD, 32'h0);
        send_command(OP_SEARCH, 32'h0000_0005, 32'h0);
        send_command(OP_MODIFY, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send_command(OP_MODIFY, 32'h1234_5678, 32'h0);
        send_command(OP_DELETE, 32'h7FFF_FFFF, 32'h0);
        send_command(OP_DELETE, 32'h0001_2345, 32'h0);
        send_command(OP_SORT, 32'h0, 32'h0);
        send_command(OP_LIST, 32'h0, 32'h0);
        send_command(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Long output hold-off while commands keep coming.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        hold_req      <= 1'b1;
        send_command(OP_LIST, 32'h0, 32'h0);
        send_command(OP_STATS, 32'h0, 32'h0);
        repeat (4) send_command(OP_APPEND, 32'h0, pick_word());
        send_command(OP_LIST, 32'h0, 32'h0);
        send_command(OP_SORT, 32'h0, 32'h0);
        wait_drained();

        random_sent = 0;
        prev_phase  = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            phase = random_sent / PHASE_ITEMS;
            if (phase > LAST_PHASE)
            begin
                phase = LAST_PHASE;
            end
            if (phase != prev_phase)
            begin
                wait_drained();
                prev_phase = phase;
                if (phase == LAST_PHASE)
                begin
                    calm = 1'b1;
                end
            end
            op = pick_op(phase);
            send_command(op, pick_word(), pick_word());
            if (op != OP_UNUSED)
            begin
                random_sent++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d commands sent, %0d result beats compared.",
                 commands_sent, beats_checked);
        $display("Covered empty, missing-key, extreme and negative cases under random stalls.");
        if (mismatch_count == 0 && pending_beats == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/vle_pkg.sv
hdl/vle_mem.sv
hdl/vle_cmp.sv
hdl/value_list_engine_unit.sv
tb/vle_result_checker.sv
tb/tb_top.sv
